// File: design/stkrot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stkrot_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int WORD_W          = 32;

   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_ROTATE = 2'd2;

   typedef logic [1:0] cell_op_type;

   localparam cell_op_type CELL_HOLD     = 2'd0;
   localparam cell_op_type CELL_SHIFT_DN = 2'd1;
   localparam cell_op_type CELL_SHIFT_UP = 2'd2;
   localparam cell_op_type CELL_ROTATE   = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

endpackage
`default_nettype wire

// File: design/stkrot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module stkrot_cell #(
   parameter int STACK_DEPTH = stkrot_pkg::STACK_DEPTH_DEF,
   parameter int INDEX       = 0
) (
   input  wire                             clock,
   input  wire stkrot_pkg::cell_op_type    cell_op,
   input  wire [$clog2(STACK_DEPTH)-1:0]   last_idx,
   input  wire stkrot_pkg::word_type       above_data,
   input  wire stkrot_pkg::word_type       below_data,
   input  wire stkrot_pkg::word_type       top_data,
   output stkrot_pkg::word_type            cell_data
);

   localparam int IW = $clog2(STACK_DEPTH);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   stkrot_pkg::word_type data_ff;
   stkrot_pkg::word_type data_in;

   always_comb begin
      data_in = data_ff;
      case (cell_op)
         stkrot_pkg::CELL_SHIFT_DN: data_in = above_data;
         stkrot_pkg::CELL_SHIFT_UP: data_in = below_data;
         stkrot_pkg::CELL_ROTATE: begin
            if (MY_IDX < last_idx) begin
               data_in = below_data;
            end else if (MY_IDX == last_idx) begin
               data_in = top_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule
`default_nettype wire

// File: design/stkrot_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module stkrot_ctrl #(
   parameter int STACK_DEPTH = stkrot_pkg::STACK_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire [1:0]                           req_kind,
   input  wire [$clog2(STACK_DEPTH+1)-1:0]     req_count,
   input  wire stkrot_pkg::word_type           top_data,
   output stkrot_pkg::cell_op_type             cell_op,
   output logic [$clog2(STACK_DEPTH)-1:0]      last_idx,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output stkrot_pkg::word_type                rsp_top,
   output logic [$clog2(STACK_DEPTH+1)-1:0]    rsp_total,
   output logic                                rsp_empty,
   output logic                                rsp_dropped
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROT  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 drop_ff, drop_in;
   logic                 ovalid_ff, ovalid_in;
   stkrot_pkg::word_type otop_ff, otop_in;
   logic [CW-1:0]        ototal_ff, ototal_in;
   logic                 oempty_ff, oempty_in;
   logic                 odrop_ff, odrop_in;
   logic                 accept;

   assign req_ready = (state_ff == ST_IDLE) && (!ovalid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign last_idx  = IW'(count_ff - 1'b1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      drop_in   = drop_ff;
      cell_op   = stkrot_pkg::CELL_HOLD;
      ovalid_in = ovalid_ff && !rsp_ready;
      otop_in   = otop_ff;
      ototal_in = ototal_ff;
      oempty_in = oempty_ff;
      odrop_in  = odrop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               drop_in  = 1'b0;
               state_in = ST_DONE;
               case (req_kind)
                  stkrot_pkg::REQ_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        drop_in = 1'b1;
                     end else begin
                        cell_op  = stkrot_pkg::CELL_SHIFT_DN;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  stkrot_pkg::REQ_POP: begin
                     if (count_ff != '0) begin
                        cell_op  = stkrot_pkg::CELL_SHIFT_UP;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  stkrot_pkg::REQ_ROTATE: begin
                     if (req_count != '0 && req_count < count_ff) begin
                        cell_op = stkrot_pkg::CELL_ROTATE;
                        rem_in  = req_count - 1'b1;
                        if (req_count != CW'(1)) begin
                           state_in = ST_ROT;
                        end
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ROT: begin
            cell_op = stkrot_pkg::CELL_ROTATE;
            rem_in  = rem_ff - 1'b1;
            if (rem_ff == CW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            ovalid_in = 1'b1;
            otop_in   = (count_ff == '0) ? '0 : top_data;
            ototal_in = count_ff;
            oempty_in = (count_ff == '0);
            odrop_in  = drop_ff;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rem_ff    <= '0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rem_ff    <= rem_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      otop_ff   <= otop_in;
      ototal_ff <= ototal_in;
      oempty_ff <= oempty_in;
      odrop_ff  <= odrop_in;
   end

   assign rsp_valid   = ovalid_ff;
   assign rsp_top     = otop_ff;
   assign rsp_total   = ototal_ff;
   assign rsp_empty   = oempty_ff;
   assign rsp_dropped = odrop_ff;

endmodule
`default_nettype wire

// File: design/stack_with_rotation.sv
// Sequence: a push, pop or no-op goes from acceptance to the DONE state, which loads the
// response register; a rotate by N rotates the whole stack N places, one cell-chain shift
// per place (the first at acceptance, the rest in the ROT state), before DONE. A new request
// is taken only back in idle, and only once the previous response is taken or being taken.
// Reset (synchronous, active high) empties the stack and drops any pending response;
// cell contents are not cleared and are never visible until written.
`timescale 1ns / 1ps
`default_nettype none
module stack_with_rotation #(
   parameter int STACK_DEPTH = stkrot_pkg::STACK_DEPTH_DEF
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_tvalid,
   output logic                                         req_tready,
   // push_value [31:0], rotate_count above it, zero padded
   input  wire [((stkrot_pkg::WORD_W + $clog2(STACK_DEPTH+1) + 7) / 8) * 8 - 1:0] req_tdata,
   // req_type
   input  wire [1:0]                                    req_tuser,
   output logic                                         rsp_tvalid,
   input  wire                                          rsp_tready,
   // top_value [31:0], entry_total above it, zero padded
   output logic [((stkrot_pkg::WORD_W + $clog2(STACK_DEPTH+1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // is_empty [0], push_dropped [1]
   output logic [1:0]                                   rsp_tuser
);

   localparam int WW = stkrot_pkg::WORD_W;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);
   localparam int DW = ((WW + CW + 7) / 8) * 8;

   stkrot_pkg::word_type    cell_q [STACK_DEPTH];
   stkrot_pkg::cell_op_type cell_op;
   logic [IW-1:0]           last_idx;
   stkrot_pkg::word_type    push_value;
   logic [CW-1:0]           rotate_count;
   stkrot_pkg::word_type    rsp_top;
   logic [CW-1:0]           rsp_total;
   logic                    rsp_empty;
   logic                    rsp_dropped;

   assign push_value   = req_tdata[WW-1:0];
   assign rotate_count = req_tdata[WW+CW-1:WW];

   stkrot_ctrl #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_count  (rotate_count),
      .top_data   (cell_q[0]),
      .cell_op    (cell_op),
      .last_idx   (last_idx),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_top    (rsp_top),
      .rsp_total  (rsp_total),
      .rsp_empty  (rsp_empty),
      .rsp_dropped(rsp_dropped)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      stkrot_pkg::word_type above_w;
      stkrot_pkg::word_type below_w;

      if (i == 0) begin : g_first
         assign above_w = push_value;
      end else begin : g_mid
         assign above_w = cell_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below_w = cell_q[i];
      end else begin : g_inner
         assign below_w = cell_q[i+1];
      end

      stkrot_cell #(
         .STACK_DEPTH(STACK_DEPTH),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .cell_op   (cell_op),
         .last_idx  (last_idx),
         .above_data(above_w),
         .below_data(below_w),
         .top_data  (cell_q[0]),
         .cell_data (cell_q[i])
      );
   end

   assign rsp_tdata = DW'({rsp_total, rsp_top});
   assign rsp_tuser = {rsp_dropped, rsp_empty};

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int STACK_DEPTH = stkrot_pkg::STACK_DEPTH_DEF;
   localparam int WORD_W      = stkrot_pkg::WORD_W;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int TDATA_W     = ((WORD_W + CNT_W + 7) / 8) * 8;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLDOFF_AT   = 300;
   localparam int HOLDOFF_LEN  = 400;

   typedef struct packed {
      stkrot_pkg::word_type top;
      logic [CNT_W-1:0]     total;
      logic                 empty;
      logic                 dropped;
   } stack_result_type;

   class stack_tracker_type;
      stkrot_pkg::word_type entries [STACK_DEPTH];
      int                   depth_now = 0;
      int unsigned          mismatch_total = 0;
      stack_result_type     pending_results [$];

      function void apply_request(logic [1:0] kind, stkrot_pkg::word_type value,
                                  logic [CNT_W-1:0] count);
         stkrot_pkg::word_type rotated [STACK_DEPTH];
         stack_result_type     res;
         int                   n;
         res = '0;
         n = int'(count);
         case (kind)
            stkrot_pkg::REQ_PUSH: begin
               if (depth_now >= STACK_DEPTH) begin
                  res.dropped = 1'b1;
               end else begin
                  entries[depth_now] = value;
                  depth_now++;
               end
            end
            stkrot_pkg::REQ_POP: begin
               if (depth_now > 0) depth_now--;
            end
            stkrot_pkg::REQ_ROTATE: begin
               if (n != 0 && n < depth_now) begin
                  for (int k = 0; k < depth_now; k++)
                     rotated[k] = entries[(k + depth_now - n) % depth_now];
                  for (int k = 0; k < depth_now; k++)
                     entries[k] = rotated[k];
               end
            end
            default: ;
         endcase
         res.total = CNT_W'(depth_now);
         res.empty = (depth_now == 0);
         if (depth_now > 0) res.top = entries[depth_now - 1];
         pending_results.push_back(res);
      endfunction

      function void match_response(stack_result_type got);
         stack_result_type want;
         if (pending_results.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("%0t: response with none outstanding: ", $time,
                        "top=%0d total=%0d empty=%b dropped=%b",
                        $signed(got.top), got.total, got.empty, got.dropped);
            return;
         end
         want = pending_results.pop_front();
         if (got.top !== want.top || got.total !== want.total ||
             got.empty !== want.empty || got.dropped !== want.dropped) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("%0t: mismatch: ", $time,
                        "expected top=%0d total=%0d empty=%b dropped=%b, ",
                        $signed(want.top), want.total, want.empty, want.dropped,
                        "got top=%0d total=%0d empty=%b dropped=%b",
                        $signed(got.top), got.total, got.empty, got.dropped);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;   // push_value, rotate_count
   logic [1:0]         req_tuser = '0;   // req_type
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;        // top_value, entry_total
   logic [1:0]         rsp_tuser;        // is_empty, push_dropped

   stack_tracker_type tracker = new;
   bit                quiet_stretch = 1'b0;

   stack_with_rotation #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_request(logic [1:0] kind, stkrot_pkg::word_type value,
                               logic [CNT_W-1:0] count);
      int unsigned gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'({count, value});
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      tracker.apply_request(kind, value, count);
   endtask

   initial begin : response_sink
      int unsigned      stall;
      int unsigned      taken;
      stack_result_type got;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_stretch ? 0 : $urandom_range(0, 15);
         if (taken == HOLDOFF_AT) stall = HOLDOFF_LEN;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.top     = rsp_tdata[WORD_W-1:0];
         got.total   = rsp_tdata[WORD_W +: CNT_W];
         got.empty   = rsp_tuser[0];
         got.dropped = rsp_tuser[1];
         tracker.match_response(got);
         taken++;
      end
   end

   initial begin : stimulus
      logic [1:0]           kind;
      stkrot_pkg::word_type value;
      logic [CNT_W-1:0]     count;
      int unsigned          pick;
      int unsigned          drift;
      int unsigned          push_cut;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty stack, unused code, extremes, rotate edges, fill to full and overflow
      send_request(stkrot_pkg::REQ_POP, 32'h0000_0000, 5'd0);
      send_request(stkrot_pkg::REQ_ROTATE, 32'hFFFF_FFFF, 5'd3);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 5'd16);
      send_request(stkrot_pkg::REQ_PUSH, 32'h8000_0000, 5'd16);
      send_request(stkrot_pkg::REQ_PUSH, 32'h7FFF_FFFF, 5'd0);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd1);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd2);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd0);
      for (int k = 0; k < STACK_DEPTH - 2; k++) begin
         value = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'h0000_0000 : $urandom;
         send_request(stkrot_pkg::REQ_PUSH, value, CNT_W'(k));
      end
      send_request(stkrot_pkg::REQ_PUSH, 32'h1234_5678, 5'd7);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd15);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd16);
      send_request(stkrot_pkg::REQ_POP, 32'h0000_0000, 5'd0);
      send_request(stkrot_pkg::REQ_ROTATE, 32'h0000_0000, 5'd14);

      drift = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) drift = $urandom_range(0, 2);
         quiet_stretch = (i >= 150 && i < 210) || (i >= 600 && i < 650);
         push_cut = (drift == 0) ? 75 : (drift == 1) ? 35 : 60;
         pick = $urandom_range(0, 99);
         if (pick < 3) kind = REQ_UNUSED;
         else if (pick < 20) kind = stkrot_pkg::REQ_ROTATE;
         else if (pick < push_cut) kind = stkrot_pkg::REQ_PUSH;
         else kind = stkrot_pkg::REQ_POP;
         case ($urandom_range(0, 9))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            default: value = $urandom;
         endcase
         if (kind == stkrot_pkg::REQ_ROTATE && tracker.depth_now > 1 &&
             $urandom_range(0, 9) < 7)
            count = CNT_W'($urandom_range(1, tracker.depth_now - 1));
         else
            count = CNT_W'($urandom_range(0, STACK_DEPTH));
         send_request(kind, value, count);
      end
      quiet_stretch = 1'b0;
      req_tvalid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (2 * STACK_DEPTH + 10) @(posedge clock);
      if (tracker.mismatch_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
design/stkrot_pkg.sv
design/stkrot_cell.sv
design/stkrot_ctrl.sv
design/stack_with_rotation.sv
tb/tb_top.sv
